// ===== design/rfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrf_pkg
// Shared types and constants for the false position root finder.
// ----------------------------------------------------------------------------
package rfrf_pkg;

    localparam int F_WIDTH   = 48;
    localparam int TOL_WIDTH = 17;
    localparam int LIM_WIDTH = 8;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_SAME_SIGN = 2'd1,
        ST_NO_CONV   = 2'd2,
        ST_ZERO_DEN  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_TOLERANCE = 1'b0,
        CFG_ITER_LIM  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FA_REQ,
        S_FA_WAIT,
        S_FB_REQ,
        S_FB_WAIT,
        S_CHECK,
        S_MUL_REQ,
        S_MUL_WAIT,
        S_DIV_REQ,
        S_DIV_WAIT,
        S_FC_REQ,
        S_FC_WAIT,
        S_TEST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

endpackage

// ===== design/rfrf_if.sv =====
// ----------------------------------------------------------------------------
// rfrf_if
// Valid/ready channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface rfrf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rfrf_mul.sv =====
// ----------------------------------------------------------------------------
// rfrf_mul
// Shift-add unsigned multiplier, one partial product bit per cycle.
// ----------------------------------------------------------------------------
module rfrf_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] r_acc, n_acc;
    logic [AW+BW-1:0] r_a, n_a;
    logic [BW-1:0]    r_b, n_b;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = {{BW{1'b0}}, i_a};
            n_b    = i_b;
            n_cnt  = CW'(BW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// ===== design/rfrf_div.sv =====
// ----------------------------------------------------------------------------
// rfrf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfrf_div #(
    parameter int NW = 128,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_d, n_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   w_sh;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_start) begin
            n_q    = i_n;
            n_rem  = '0;
            n_d    = i_d;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                n_rem = w_sh - {1'b0, r_d};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== design/regula_falsi_root_finder_top.sv =====
// ----------------------------------------------------------------------------
// regula_falsi_root_finder_top
// False position root finder for f(x) = x*x - 2x - 8 in signed fixed point.
//
// Input channel s_in carries one beat {start_a, start_b}; output channel
// m_out carries one beat {root, f_at_root, iterations_used, status} per
// input beat. Configuration is a plain write port: index 0 tolerance,
// index 1 iteration limit.
// One item is in flight at a time; s_in.ready is high only when idle.
// A shift-add multiplier evaluates every square and the product fb*(b-a);
// a restoring divider forms the quotient. A same-sign refusal is offered
// as soon as f(b) has been evaluated. s_in.ready returns the cycle after
// the result beat is taken.
// The result sits in a register until m_out.ready; the block waits.
// Synchronous reset returns the sequencer to idle and the registers to
// tolerance 655 and iteration limit 100.
// ----------------------------------------------------------------------------
module regula_falsi_root_finder_top #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [rfrf_pkg::TOL_WIDTH-1:0] i_cfg_data,
    rfrf_if.sink                         s_in,
    rfrf_if.source                       m_out
);
    localparam int FW = rfrf_pkg::F_WIDTH;
    localparam int MW = 64;
    localparam int PW = 2 * MW;
    localparam int XW = 66;
    localparam logic [MW-1:0] CAP = MW'(1) << 62;
    localparam logic signed [XW-1:0] FMAX = (XW'(1) <<< (FW - 1)) - XW'(1);
    localparam logic signed [XW-1:0] FMIN = -(XW'(1) <<< (FW - 1));
    localparam logic signed [XW-1:0] WMAX = (XW'(1) <<< (WORD_WIDTH - 1)) - XW'(1);
    localparam logic signed [XW-1:0] WMIN = -(XW'(1) <<< (WORD_WIDTH - 1));

    rfrf_pkg::t_state r_st, n_st;

    logic [rfrf_pkg::TOL_WIDTH-1:0] r_tol;
    logic [rfrf_pkg::LIM_WIDTH-1:0] r_lim;

    logic signed [WORD_WIDTH-1:0] r_a, r_b, r_c, n_a, n_b, n_c;
    logic signed [FW-1:0]         r_fa, r_fb, r_fc, n_fa, n_fb, n_fc;
    logic [rfrf_pkg::LIM_WIDTH-1:0] r_it, n_it;
    logic signed [WORD_WIDTH-1:0] r_root, n_root;
    logic signed [FW-1:0]         r_froot, n_froot;
    rfrf_pkg::t_status            r_stat, n_stat;
    logic                         r_neg, n_neg;
    logic [MW-1:0]                r_dmag, n_dmag;
    logic [MW-1:0]                r_q, n_q;
    logic                         w_ov;

    logic          w_mul_start, w_div_start;
    logic [MW-1:0] w_ma, w_mb;
    logic [PW-1:0] w_p, w_dq;
    logic          w_mul_done, w_div_done;
    logic [PW-1:0] w_dn;
    logic          r_fc_go;
    logic          w_start_any;

    rfrf_mul #(.AW(MW), .BW(MW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_any),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mul_done), .o_p(w_p)
    );

    rfrf_div #(.NW(PW), .DW(MW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_n(w_dn), .i_d(r_dmag), .o_done(w_div_done), .o_q(w_dq)
    );

    function automatic logic [MW-1:0] f_mag(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v < 0) ? -v : v;
        return t[MW-1:0];
    endfunction

    // f from the square product and x
    function automatic logic signed [FW-1:0] f_eval(
        input logic [PW-1:0] sq, input logic signed [WORD_WIDTH-1:0] x);
        logic [PW:0]          r;
        logic [PW:0]          sh;
        logic [MW-1:0]        cw;
        logic signed [XW-1:0] s;
        r  = {1'b0, sq} + ((PW+1)'(1) << (FRAC_BITS - 1));
        sh = r >> FRAC_BITS;
        cw = (sh > (PW+1)'(CAP)) ? CAP : sh[MW-1:0];
        s  = $signed({2'b00, cw}) - (XW'(x) <<< 1) - (XW'(8) <<< FRAC_BITS);
        if (s > FMAX) s = FMAX;
        if (s < FMIN) s = FMIN;
        return s[FW-1:0];
    endfunction

    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_span, w_d, w_cx;
    logic [MW-1:0]        w_fc_mag;

    always_comb begin
        w_span = XW'(r_b) - XW'(r_a);
        w_d    = XW'(r_fb) - XW'(r_fa);
        w_cx   = XW'(r_b) - (r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q}));
        w_fc_mag = f_mag(XW'(r_fc));
        w_x    = XW'(r_a);
        unique case (r_st)
            rfrf_pkg::S_FB_REQ, rfrf_pkg::S_FB_WAIT: w_x = XW'(r_b);
            rfrf_pkg::S_FC_REQ, rfrf_pkg::S_FC_WAIT: w_x = XW'(r_c);
            default: w_x = XW'(r_a);
        endcase
    end

    always_comb begin
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_ma = f_mag(w_x);
        w_mb = f_mag(w_x);
        w_dn = w_p;
        w_ov = 1'b0;
        n_st = r_st;
        n_a = r_a; n_b = r_b; n_c = r_c;
        n_fa = r_fa; n_fb = r_fb; n_fc = r_fc;
        n_it = r_it; n_root = r_root; n_froot = r_froot; n_stat = r_stat;
        n_neg = r_neg; n_dmag = r_dmag; n_q = r_q;
        unique case (r_st)
            rfrf_pkg::S_IDLE: begin
                if (s_in.valid) begin
                    n_a  = s_in.data[2*WORD_WIDTH-1:WORD_WIDTH];
                    n_b  = s_in.data[WORD_WIDTH-1:0];
                    n_it = '0;
                    n_st = rfrf_pkg::S_FA_REQ;
                end
            end
            rfrf_pkg::S_FA_REQ: begin
                w_mul_start = 1'b1;
                n_st = rfrf_pkg::S_FA_WAIT;
            end
            rfrf_pkg::S_FA_WAIT: begin
                if (w_mul_done) begin
                    n_fa = f_eval(w_p, r_a);
                    n_st = rfrf_pkg::S_FB_REQ;
                end
            end
            rfrf_pkg::S_FB_REQ: begin
                w_mul_start = 1'b1;
                n_st = rfrf_pkg::S_FB_WAIT;
            end
            rfrf_pkg::S_FB_WAIT: begin
                if (w_mul_done) begin
                    n_fb = f_eval(w_p, r_b);
                    n_root = r_b;
                    n_froot = n_fb;
                    n_stat = rfrf_pkg::ST_NO_CONV;
                    if ((r_fa > 0 && n_fb > 0) || (r_fa < 0 && n_fb < 0)) begin
                        n_root = '0;
                        n_froot = '0;
                        n_stat = rfrf_pkg::ST_SAME_SIGN;
                        n_st = rfrf_pkg::S_OUT;
                    end else begin
                        n_st = rfrf_pkg::S_CHECK;
                    end
                end
            end
            rfrf_pkg::S_CHECK: begin
                if (r_it >= r_lim) begin
                    n_st = rfrf_pkg::S_OUT;
                end else if (w_d == 0) begin
                    n_stat = rfrf_pkg::ST_ZERO_DEN;
                    n_root = r_b;
                    n_froot = r_fb;
                    n_st = rfrf_pkg::S_OUT;
                end else begin
                    n_neg  = ((r_fb < 0) != (w_span < 0)) != (w_d < 0);
                    n_dmag = f_mag(w_d);
                    n_st   = rfrf_pkg::S_MUL_REQ;
                end
            end
            rfrf_pkg::S_MUL_REQ: begin
                w_ma = f_mag(XW'(r_fb));
                w_mb = f_mag(w_span);
                w_mul_start = 1'b1;
                n_st = rfrf_pkg::S_MUL_WAIT;
            end
            rfrf_pkg::S_MUL_WAIT: begin
                if (w_mul_done) begin
                    n_st = rfrf_pkg::S_DIV_REQ;
                end
            end
            rfrf_pkg::S_DIV_REQ: begin
                w_div_start = 1'b1;
                n_st = rfrf_pkg::S_DIV_WAIT;
            end
            rfrf_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    w_ov = (w_dq[PW-1:MW] != '0) || (w_dq[MW-1:0] > CAP);
                    n_q  = w_ov ? CAP : w_dq[MW-1:0];
                    n_st = rfrf_pkg::S_FC_REQ;
                end
            end
            rfrf_pkg::S_FC_REQ: begin
                if (w_cx > WMAX) n_c = WMAX[WORD_WIDTH-1:0];
                else if (w_cx < WMIN) n_c = WMIN[WORD_WIDTH-1:0];
                else n_c = w_cx[WORD_WIDTH-1:0];
                n_st = rfrf_pkg::S_FC_WAIT;
            end
            rfrf_pkg::S_FC_WAIT: begin
                if (w_mul_done) begin
                    n_fc = f_eval(w_p, r_c);
                    n_it = r_it + 1'b1;
                    n_root = r_c;
                    n_froot = n_fc;
                    n_st = rfrf_pkg::S_TEST;
                end
            end
            rfrf_pkg::S_TEST: begin
                if (w_fc_mag < MW'(r_tol)) begin
                    n_stat = rfrf_pkg::ST_FOUND;
                    n_st = rfrf_pkg::S_OUT;
                end else begin
                    if ((r_fa < 0 && r_fc > 0) || (r_fa > 0 && r_fc < 0)) begin
                        n_b = r_c;
                        n_fb = r_fc;
                    end else begin
                        n_a = r_c;
                        n_fa = r_fc;
                    end
                    n_st = rfrf_pkg::S_CHECK;
                end
            end
            rfrf_pkg::S_OUT: begin
                if (m_out.ready) begin
                    n_st = rfrf_pkg::S_IDLE;
                end
            end
            default: n_st = rfrf_pkg::S_IDLE;
        endcase
    end

    // c is registered in FC_REQ; start its square in the cycle after, from r_fc_go
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_go <= 1'b0;
        end else begin
            r_fc_go <= (r_st == rfrf_pkg::S_FC_REQ);
        end
    end

    assign w_start_any = w_mul_start | r_fc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= rfrf_pkg::S_IDLE;
            r_tol <= rfrf_pkg::TOL_WIDTH'(655);
            r_lim <= rfrf_pkg::LIM_WIDTH'(100);
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (rfrf_pkg::t_cfg_idx'(i_cfg_idx))
                    rfrf_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data;
                    rfrf_pkg::CFG_ITER_LIM:
                        r_lim <= i_cfg_data[rfrf_pkg::LIM_WIDTH-1:0];
                    default: r_tol <= r_tol;
                endcase
            end
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c;
        r_fa <= n_fa; r_fb <= n_fb; r_fc <= n_fc;
        r_it <= n_it; r_root <= n_root; r_froot <= n_froot; r_stat <= n_stat;
        r_neg <= n_neg; r_dmag <= n_dmag; r_q <= n_q;
    end

    assign s_in.ready  = (r_st == rfrf_pkg::S_IDLE);
    assign m_out.valid = (r_st == rfrf_pkg::S_OUT);
    assign m_out.data  = {r_root, r_froot, r_it, r_stat};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> m_out.valid)
        else $error("result beat dropped while stalled");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in.ready && m_out.valid))
        else $error("input taken while result pending");
    a_it_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> (r_it <= r_lim || r_stat == rfrf_pkg::ST_SAME_SIGN))
        else $error("iteration count beyond limit");
endmodule
